/* rtl/ils_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// opcodes, status codes and the scan word carried along the cell row
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int FPOS_W   = 6;
    localparam int LEN_W    = 7;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // partial result handed from one cell to the next
    typedef struct packed {
        logic              hit;
        logic [FPOS_W-1:0] fpos;
        logic [DATA_W-1:0] rdata;
    } t_scan;

endpackage

/* rtl/ils_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_cell
// one list slot: shifts with its neighbors and adds its part to the scan word
// ----------------------------------------------------------------------------
module ils_cell #(
    parameter int IDX   = 0,
    parameter int PW    = 7
) (
    input  logic                       i_clk,
    input  logic                       i_upd,
    input  logic [ils_pkg::OP_W-1:0]   i_op,
    input  logic [PW-1:0]              i_pos,
    input  logic [PW-1:0]              i_count,
    input  logic [ils_pkg::DATA_W-1:0] i_val,
    input  logic [ils_pkg::DATA_W-1:0] i_left,
    input  logic [ils_pkg::DATA_W-1:0] i_right,
    input  ils_pkg::t_scan             i_scan,
    output logic [ils_pkg::DATA_W-1:0] o_entry,
    output ils_pkg::t_scan             o_scan
);
    import ils_pkg::*;

    localparam logic [PW-1:0] MY = PW'(IDX);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    t_scan             r_scan;
    t_scan             n_scan;

    always_comb begin
        n_entry = r_entry;
        if (i_upd) begin
            case (i_op)
                OP_INSERT: begin
                    if (MY == i_pos) begin
                        n_entry = i_val;
                    end else if (MY > i_pos) begin
                        n_entry = i_left;
                    end
                end
                OP_ERASE: begin
                    if (MY >= i_pos) begin
                        n_entry = i_right;
                    end
                end
                OP_WRITE: begin
                    if (MY == i_pos) begin
                        n_entry = i_val;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_scan = i_scan;
        case (i_op)
            OP_READ: begin
                if (MY == i_pos) begin
                    n_scan.hit   = 1'b1;
                    n_scan.rdata = r_entry;
                end
            end
            OP_FIND: begin
                if (!i_scan.hit && (MY < i_count) && (r_entry == i_val)) begin
                    n_scan.hit  = 1'b1;
                    n_scan.fpos = FPOS_W'(IDX);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_scan  <= n_scan;
    end

    assign o_entry = r_entry;
    assign o_scan  = r_scan;

endmodule

/* rtl/indexed_list_store_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_top
// ordered list of signed 32-bit values held in a row of CAPACITY cells
// ----------------------------------------------------------------------------
// append, insert, erase, write: execute state, then done state, then the output register
// read, find: execute state, scan state, then done state and the output register; the scan
//   state lasts while the scan word steps through the cell row one register per cycle
// one request in flight; a finished result may wait in the output register
// reset: synchronous active low, empties the list; slot contents are not cleared
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
    parameter int CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ils_pkg::OP_W-1:0]     i_opcode,
    input  logic [ils_pkg::POS_W-1:0]    i_position,
    input  logic signed [ils_pkg::DATA_W-1:0] i_item_value,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ils_pkg::STATUS_W-1:0] o_status,
    output logic signed [ils_pkg::DATA_W-1:0] o_read_value,
    output logic [ils_pkg::FPOS_W-1:0]   o_found_position,
    output logic [ils_pkg::LEN_W-1:0]    o_length
);
    import ils_pkg::*;

    // count holds 0..CAPACITY; compares run at the wider of count and position
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int SCW = $clog2(CAPACITY);

    localparam logic [CW-1:0]  CAP_CNT   = CW'(CAPACITY);
    localparam logic [SCW-1:0] SCAN_LAST = SCW'(CAPACITY - 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // control
    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [SCW-1:0]      r_scan_cnt;
    logic [SCW-1:0]      n_scan_cnt;
    logic                r_out_valid;
    logic                n_out_valid;

    // held request and result payload
    logic [OP_W-1:0]     r_op;
    logic [POS_W-1:0]    r_pos;
    logic [DATA_W-1:0]   r_val;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_rdata;
    logic [FPOS_W-1:0]   r_out_fpos;
    logic [LEN_W-1:0]    r_out_len;

    // request decode
    logic [PW-1:0]       w_pos;
    logic [PW-1:0]       w_cnt;
    logic                w_full;
    logic [STATUS_W-1:0] w_status;
    logic                w_upd;
    logic [OP_W-1:0]     w_cell_op;
    logic [PW-1:0]       w_cell_pos;
    logic                w_out_free;
    logic                w_accept;

    // cell row
    logic [DATA_W-1:0]   w_entry [CAPACITY];
    t_scan               w_scan  [CAPACITY+1];
    t_scan               w_scan_end;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_pos      = PW'(r_pos);
    assign w_cnt      = PW'(r_count);
    assign w_full     = (r_count == CAP_CNT);

    // status of the held request against the length before it
    always_comb begin
        w_status = ST_OK;
        case (r_op)
            OP_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end
            end
            OP_INSERT: begin
                if (w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end
            end
            OP_ERASE, OP_WRITE, OP_READ: begin
                if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end
            end
            default: ;
        endcase
    end

    // append is an insert at the tail
    always_comb begin
        w_cell_op  = r_op;
        w_cell_pos = w_pos;
        if (r_op == OP_APPEND) begin
            w_cell_op  = OP_INSERT;
            w_cell_pos = w_cnt;
        end
    end

    // the list moves only in the execute cycle and only on success
    assign w_upd = (r_state == S_EXEC) && (w_status == ST_OK);

    assign w_scan[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        // the last slot has no right neighbor; erase leaves it as don't-care
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        ils_cell #(
            .IDX (g),
            .PW  (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_upd   (w_upd),
            .i_op    (w_cell_op),
            .i_pos   (w_cell_pos),
            .i_count (w_cnt),
            .i_val   (r_val),
            .i_left  (w_left),
            .i_right (w_right),
            .i_scan  (w_scan[g]),
            .o_entry (w_entry[g]),
            .o_scan  (w_scan[g+1])
        );
    end

    assign w_scan_end = w_scan[CAPACITY];

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_scan_cnt = r_scan_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_status == ST_OK) begin
                    case (r_op)
                        OP_APPEND, OP_INSERT: n_count = r_count + 1'b1;
                        OP_ERASE:             n_count = r_count - 1'b1;
                        default: ;
                    endcase
                end
                // reads and finds wait for the scan word to clear the row
                if ((r_op == OP_READ) || (r_op == OP_FIND)) begin
                    n_state    = S_SCAN;
                    n_scan_cnt = SCAN_LAST;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_scan_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_scan_cnt = r_scan_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if ((r_state == S_DONE) && w_out_free) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan_cnt  <= n_scan_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_opcode;
            r_pos <= i_position;
            r_val <= i_item_value;
        end
        if (r_state == S_EXEC) begin
            r_status <= w_status;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            // count already reflects this request here
            r_out_len <= LEN_W'(r_count);
            if (r_op == OP_FIND) begin
                r_out_status <= w_scan_end.hit ? ST_OK : ST_NOTFOUND;
                r_out_fpos   <= w_scan_end.hit ? w_scan_end.fpos : '0;
            end else begin
                r_out_status <= r_status;
                r_out_fpos   <= '0;
            end
            if ((r_op == OP_READ) && (r_status == ST_OK)) begin
                r_out_rdata <= w_scan_end.rdata;
            end else begin
                r_out_rdata <= '0;
            end
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_read_value     = r_out_rdata;
    assign o_found_position = r_out_fpos;
    // held with the rest of the word while it waits
    assign o_length         = r_out_len;

`ifndef SYNTHESIS
    // the list never grows past its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("list length above capacity");

    // a successful append or insert grows the list by one
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && (w_status == ST_OK) &&
        ((r_op == OP_APPEND) || (r_op == OP_INSERT))
        |=> r_count == $past(r_count) + 1'b1)
        else $error("length did not grow on append or insert");

    // a successful erase shrinks the list by one
    a_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && (w_status == ST_OK) && (r_op == OP_ERASE)
        |=> r_count == $past(r_count) - 1'b1)
        else $error("length did not shrink on erase");

    // an accepted request always starts in the execute cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC)
        else $error("accepted request did not enter execute");
`endif

endmodule
